/* src/lpht_pkg.sv */
// Shared types and codes for the linear probing hash table.
package lpht_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Decision for one probed slot.
  typedef struct packed {
    logic    stop;
    logic    wr_live;
    logic    wr_tomb;
    logic    inc;
    logic    dec;
    logic    hit;
    status_e status;
  } eval_t;

endpackage

/* src/linear_probe_hash_table.sv */
// Open-addressing hash table with linear probing and tombstones: top level.
// After reset the block sweeps the slot status memory, one slot per cycle, up
// to the last slot before in_ready_o first rises. Each transaction (insert,
// delete or lookup) then runs alone: it is taken into input registers, the home
// slot is computed (by mask when TABLE_SIZE is a power of two, else through the
// reciprocal multiply remainder unit), the memory read data is registered,
// then one probed slot per cycle goes through the shared slot compare until the
// probe stops (at most TABLE_SIZE slots), and the result is loaded into the
// output register once it is free. The result register lets the next
// transaction start while the previous result waits to be taken.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::DATA_W-1:0]   value_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [lpht_pkg::DATA_W-1:0]   value_out_o,
  output logic [lpht_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                          is_empty_o
);

  localparam int unsigned AW   = $clog2(TABLE_SIZE);
  localparam int unsigned CW   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned KW   = lpht_pkg::KEY_W;
  localparam int unsigned DW   = lpht_pkg::DATA_W;
  localparam int unsigned NW   = lpht_pkg::COUNT_W;
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_SIZE - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] eval_addr_q, eval_addr_d;
  logic [AW-1:0] probe_n_q, probe_n_d;
  logic          have_q, have_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  logic [1:0]    action_q, action_d;
  logic [KW-1:0] key_q, key_d;
  logic [DW-1:0] value_q, value_d;
  logic [2:0]    res_status_q, res_status_d;
  logic [DW-1:0] res_value_q, res_value_d;
  logic [2:0]    out_status_q, out_status_d;
  logic [DW-1:0] out_value_q, out_value_d;
  logic [NW-1:0] out_count_q, out_count_d;
  logic          out_empty_q, out_empty_d;

  logic [AW-1:0]       addr_next;
  logic                accept;
  logic                home_done;
  logic [AW-1:0]       home;
  logic                st_we;
  logic [AW-1:0]       st_waddr;
  logic [1:0]          st_wdata;
  logic [1:0]          st_rdata;
  logic                kv_we;
  logic [KW+DW-1:0]    kv_rdata;
  lpht_pkg::eval_t     ev;
  logic [CW+NW-1:0]    count_ext;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign addr_next  = (addr_q == LastSlot) ? '0 : addr_q + 1'b1;
  assign count_ext  = {{NW{1'b0}}, count_q};

  lpht_home #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .key_i  (key_i),
    .done_o (home_done),
    .home_o (home)
  );

  lpht_ram #(
    .WIDTH(2),
    .DEPTH(TABLE_SIZE)
  ) u_status_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(addr_q),
    .rdata_o(st_rdata)
  );

  lpht_ram #(
    .WIDTH(KW + DW),
    .DEPTH(TABLE_SIZE)
  ) u_kv_ram (
    .clk_i  (clk_i),
    .we_i   (kv_we),
    .waddr_i(eval_addr_q),
    .wdata_i({key_q, value_q}),
    .raddr_i(addr_q),
    .rdata_o(kv_rdata)
  );

  lpht_slot_eval u_eval (
    .action_i     (action_q),
    .key_i        (key_q),
    .slot_status_i(st_rdata),
    .slot_key_i   (kv_rdata[KW+DW-1:DW]),
    .last_probe_i (probe_n_q == LastSlot),
    .eval_o       (ev)
  );

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    eval_addr_d  = eval_addr_q;
    probe_n_d    = probe_n_q;
    have_d       = have_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    action_d     = action_q;
    key_d        = key_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    st_we        = 1'b0;
    st_waddr     = eval_addr_q;
    st_wdata     = lpht_pkg::SLOT_LIVE;
    kv_we        = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = addr_q;
        st_wdata = lpht_pkg::SLOT_EMPTY;
        addr_d   = addr_next;
        if (addr_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          key_d    = key_i;
          value_d  = value_in_i;
          state_d  = S_HASH;
        end
      end
      S_HASH: begin
        if (home_done) begin
          addr_d    = home;
          probe_n_d = '0;
          have_d    = 1'b0;
          state_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        // keep reading ahead; registered read data belongs to the address of the previous cycle
        addr_d      = addr_next;
        eval_addr_d = addr_q;
        have_d      = 1'b1;
        if (have_q) begin
          probe_n_d = probe_n_q + 1'b1;
          if (ev.stop) begin
            st_we    = ev.wr_live || ev.wr_tomb;
            st_wdata = ev.wr_tomb ? lpht_pkg::SLOT_TOMB : lpht_pkg::SLOT_LIVE;
            kv_we    = ev.wr_live;
            if (ev.inc) begin
              count_d = count_q + CW'(1);
            end else if (ev.dec) begin
              count_d = count_q - CW'(1);
            end
            res_status_d = ev.status;
            res_value_d  = ev.hit ? kv_rdata[DW-1:0] : '0;
            state_d      = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_count_d  = count_ext[NW-1:0];
          out_empty_d  = count_q == '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      eval_addr_q <= '0;
      probe_n_q   <= '0;
      have_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      eval_addr_q <= eval_addr_d;
      probe_n_q   <= probe_n_d;
      have_q      <= have_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    key_q        <= key_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign value_out_o   = out_value_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_SIZE))
    else $error("live entry count exceeds table size");

  a_accept_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_HASH)
    else $error("accepted transaction did not start home slot computation");

  a_tomb_delete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_we && state_q == S_PROBE && st_wdata == lpht_pkg::SLOT_TOMB)
      |-> action_q == lpht_pkg::ACT_DELETE)
    else $error("tombstone written by an action other than delete");

endmodule

/* src/lpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lpht_home.sv */
// Home slot unit: key modulo table size, by mask or by reciprocal multiplication.
module lpht_home #(
  parameter int unsigned TABLE_SIZE = 256,
  localparam int unsigned AW = $clog2(TABLE_SIZE)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  output logic                       done_o,
  output logic [AW-1:0]              home_o
);

  localparam bit IsPow2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  logic done_q;
  assign done_o = done_q;

  generate
    if (IsPow2) begin : g_mask
      logic [AW-1:0] home_q;

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          home_q <= key_i[AW-1:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      assign home_o = home_q;
    end else begin : g_recip
      // The reciprocal estimate of the quotient is exact or one short, so the
      // remainder left over is below twice the modulus: one compare and
      // subtract finishes it. Only the low AW+1 bits take part.
      localparam int unsigned Shift   = 31 + AW;
      localparam logic [31:0] Magic   = 32'((64'd1 << Shift) / 64'(TABLE_SIZE));
      localparam logic [AW:0] Modulus = (AW+1)'(TABLE_SIZE);

      logic [63:0]   prod_q;
      logic [AW:0]   key_lo_q;
      logic [AW:0]   quot_lo;
      logic [AW:0]   quot_mod;
      logic [AW:0]   rem_d;
      logic [AW:0]   rem_q;
      logic [AW:0]   rem_sub;
      logic [AW-1:0] home_q;
      logic          mul_done_q;
      logic          rem_done_q;

      assign quot_lo  = prod_q[Shift +: (AW+1)];
      assign quot_mod = quot_lo * Modulus;
      assign rem_d    = key_lo_q - quot_mod;
      assign rem_sub  = rem_q - Modulus;

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          prod_q   <= 64'(key_i) * 64'(Magic);
          key_lo_q <= key_i[AW:0];
        end
        if (mul_done_q) begin
          rem_q <= rem_d;
        end
        if (rem_done_q) begin
          home_q <= (rem_q >= Modulus) ? rem_sub[AW-1:0] : rem_q[AW-1:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mul_done_q <= 1'b0;
          rem_done_q <= 1'b0;
          done_q     <= 1'b0;
        end else begin
          mul_done_q <= start_i;
          rem_done_q <= mul_done_q;
          done_q     <= rem_done_q;
        end
      end

      assign home_o = home_q;
    end
  endgenerate

endmodule

/* src/lpht_slot_eval.sv */
// Probe decision for one slot: stop, write back and result status.
module lpht_slot_eval (
  input  logic [1:0]                 action_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  input  logic [1:0]                 slot_status_i,
  input  logic [lpht_pkg::KEY_W-1:0] slot_key_i,
  input  logic                       last_probe_i,
  output lpht_pkg::eval_t            eval_o
);

  logic live;
  logic empty;
  logic match;

  assign live  = slot_status_i == lpht_pkg::SLOT_LIVE;
  assign empty = slot_status_i == lpht_pkg::SLOT_EMPTY;
  assign match = live && (slot_key_i == key_i);

  always_comb begin
    eval_o        = '0;
    eval_o.status = lpht_pkg::ST_MISSING;
    unique case (action_i)
      lpht_pkg::ACT_INSERT: begin
        if (!live) begin
          eval_o.stop    = 1'b1;
          eval_o.wr_live = 1'b1;
          eval_o.inc     = 1'b1;
          eval_o.status  = lpht_pkg::ST_INSERTED;
        end else if (match) begin
          eval_o.stop    = 1'b1;
          eval_o.wr_live = 1'b1;
          eval_o.status  = lpht_pkg::ST_UPDATED;
        end else if (last_probe_i) begin
          eval_o.stop   = 1'b1;
          eval_o.status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::ACT_DELETE: begin
        if (match) begin
          eval_o.stop    = 1'b1;
          eval_o.wr_tomb = 1'b1;
          eval_o.dec     = 1'b1;
          eval_o.hit     = 1'b1;
          eval_o.status  = lpht_pkg::ST_REMOVED;
        end else if (empty || last_probe_i) begin
          eval_o.stop = 1'b1;
        end
      end
      lpht_pkg::ACT_LOOKUP: begin
        if (match) begin
          eval_o.stop   = 1'b1;
          eval_o.hit    = 1'b1;
          eval_o.status = lpht_pkg::ST_FOUND;
        end else if (empty || last_probe_i) begin
          eval_o.stop = 1'b1;
        end
      end
      default: begin
        // unused action: report not found at once
        eval_o.stop = 1'b1;
      end
    endcase
  end

endmodule
